// ===== rtl/skvt_pkg.sv =====
// Package for the sorted key/value table: field widths, result codes,
// request codes and the structs shared between the top level and the cells.
// No dependencies.
package skvt_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ActW    = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountW  = 5;

  // Request codes
  localparam logic [ActW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActW-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ActW-1:0] ACT_REMOVE = 2'd2;

  // Result codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  // One slot of the table
  typedef struct packed {
    logic                    valid;
    logic signed [KeyW-1:0]  key;
    logic        [DataW-1:0] data;
  } entry_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic                    rem_en;
    logic signed [KeyW-1:0]  key;
    logic        [DataW-1:0] data;
  } cmd_t;

endpackage

// ===== rtl/skvt_if.sv =====
// Channel interfaces of the sorted key/value table: request and response.
// Depends on skvt_pkg.
interface skvt_req_if import skvt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [ActW-1:0]  action;
  logic signed [KeyW-1:0]  key;
  logic        [DataW-1:0] data_value;

  modport source (output valid, action, key, data_value, input ready);
  modport sink   (input valid, action, key, data_value, output ready);
endinterface

interface skvt_rsp_if import skvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatW-1:0]   status;
  logic [DataW-1:0]   data_out;
  logic [CountW-1:0]  entry_count;

  modport source (output valid, status, data_out, entry_count, input ready);
  modport sink   (input valid, status, data_out, entry_count, output ready);
endinterface

// ===== rtl/skvt_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast key and shifts in from its left or right neighbor.
// Depends on skvt_pkg.
module skvt_cell import skvt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  entry_t left_i,
  input  logic   left_gt_i,
  input  entry_t right_i,
  output entry_t entry_o,
  output logic   gt_o,
  output logic   eq_o
);

  entry_t ent_q, ent_d;
  logic   gt_q, gt_d;
  logic   eq_q, eq_d;

  // Compare step: flags only for valid slots
  always_comb begin
    gt_d = gt_q;
    eq_d = eq_q;
    if (cmd_i.cmp_en) begin
      gt_d = ent_q.valid && (ent_q.key > cmd_i.key);
      eq_d = ent_q.valid && (ent_q.key == cmd_i.key);
    end
  end

  // Update step: insert shifts up, remove shifts down
  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins_en) begin
      if (left_gt_i) begin
        ent_d = left_i;
      end else if ((gt_q || !ent_q.valid) && left_i.valid) begin
        // first slot above the smaller keys takes the new entry
        ent_d.valid = 1'b1;
        ent_d.key   = cmd_i.key;
        ent_d.data  = cmd_i.data;
      end
    end else if (cmd_i.rem_en) begin
      if (gt_q || eq_q) begin
        ent_d = right_i;
      end
    end
  end

  // Slot and compare flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      gt_q  <= 1'b0;
      eq_q  <= 1'b0;
    end else begin
      ent_q <= ent_d;
      gt_q  <= gt_d;
      eq_q  <= eq_d;
    end
  end

  assign entry_o = ent_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// Sorted key/value table: a chain of ENTRIES cells kept in ascending signed
// key order. A request passes through the transfer, a compare cycle in
// which every cell checks its key against the request key, and an update
// cycle in which the cells shift one place up (insert) or down (remove) and
// the result is registered; the next request is taken only after that, so
// the block takes no new request before the last one is through. The result
// stays in its output register until transferred; the update cycle waits
// while an older result is still held. Depends on skvt_pkg and skvt_if.
module sorted_key_value_table import skvt_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skvt_req_if.sink  req_i,
  skvt_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned ExtW = (CntW > CountW) ? CntW : CountW;

  localparam entry_t LeftEdge  = '{valid: 1'b1, key: '0, data: '0};
  localparam entry_t RightEdge = '{valid: 1'b0, key: '0, data: '0};

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e             state_q;
  logic [ActW-1:0]    act_q;
  logic signed [KeyW-1:0] key_q;
  logic [DataW-1:0]   data_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               rsp_valid_q;
  logic [StatW-1:0]   status_q, status_d;
  logic [DataW-1:0]   dout_q, dout_d;
  logic [CountW-1:0]  ecount_q;
  logic [ExtW-1:0]    count_ext;

  cmd_t               cmd;
  entry_t             cells  [ENTRIES];
  logic [ENTRIES-1:0] gt, eq;
  logic               hit, full, upd_go;
  logic [DataW-1:0]   hit_data;

  // Cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    skvt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    ((i == 0) ? LeftEdge : cells[(i == 0) ? 0 : i - 1]),
      .left_gt_i ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .right_i   ((i == ENTRIES - 1) ? RightEdge
                                     : cells[(i == ENTRIES - 1) ? i : i + 1]),
      .entry_o   (cells[i]),
      .gt_o      (gt[i]),
      .eq_o      (eq[i])
    );
  end

  // Hit and data of the matching slot
  always_comb begin
    hit      = 1'b0;
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit      = hit | eq[i];
      hit_data = hit_data | (eq[i] ? cells[i].data : '0);
    end
  end

  assign full   = (count_q == CntW'(ENTRIES));
  assign upd_go = (state_q == S_UPD) && (!rsp_valid_q || rsp_o.ready);

  // Commands to the chain and result of the update cycle
  always_comb begin
    cmd.cmp_en = (state_q == S_CMP);
    cmd.ins_en = 1'b0;
    cmd.rem_en = 1'b0;
    cmd.key    = key_q;
    cmd.data   = data_q;
    status_d   = ST_NOT_FOUND;
    dout_d     = '0;
    count_d    = count_q;
    case (act_q)
      ACT_INSERT: begin
        if (hit) begin
          status_d = ST_DUPLICATE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d   = ST_OK;
          cmd.ins_en = upd_go;
          count_d    = count_q + 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit) begin
          status_d = ST_OK;
          dout_d   = hit_data;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          status_d   = ST_OK;
          cmd.rem_en = upd_go;
          count_d    = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  assign count_ext = ExtW'(count_d);

  // Sequencer, request register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            state_q     <= S_IDLE;
            count_q     <= count_d;
            rsp_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q  <= req_i.action;
      key_q  <= req_i.key;
      data_q <= req_i.data_value;
    end
    if (upd_go) begin
      status_q <= status_d;
      dout_q   <= dout_d;
      ecount_q <= count_ext[CountW-1:0];
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.data_out    = dout_q;
  assign rsp_o.entry_count = ecount_q;

endmodule
